@@ hw/rtl/trb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trb_pkg
// Shared types, codes and constants of the transmit FIFO refill batch policy.
// ----------------------------------------------------------------------------
package trb_pkg;

  // Default values of the top level parameters
  localparam int WORDS_PER_FRAME_DEF  = 180;
  localparam int MAX_BATCH_FRAMES_DEF = 11;

  // Field widths
  localparam int FRAME_CNT_W = 6;    // frame counts and frame registers
  localparam int WORD_CNT_W  = 16;   // FIFO word counts
  localparam int AGE_W       = 16;   // microsecond ages and waits
  localparam int WRITTEN_W   = 4;
  localparam int BATCH_W     = 4;
  // Frame thresholds scaled to words: 63 frames of up to 4096 words
  localparam int THR_W       = 18;

  localparam int IN_DATA_W   = 64;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 32;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;

  // Poll times in microseconds
  localparam logic [AGE_W-1:0] IDLE_POLL_US  = AGE_W'(1000);
  localparam logic [AGE_W-1:0] SPACE_POLL_US = AGE_W'(500);
  localparam int BIG_QUEUE_FACTOR = 2;

  // Register reset values
  localparam logic [FRAME_CNT_W-1:0] RST_PREFILL_LOW    = FRAME_CNT_W'(3);
  localparam logic [FRAME_CNT_W-1:0] RST_PREFILL_HIGH   = FRAME_CNT_W'(8);
  localparam logic [FRAME_CNT_W-1:0] RST_NORMAL_TARGET  = FRAME_CNT_W'(2);
  localparam logic [FRAME_CNT_W-1:0] RST_PREFILL_TARGET = FRAME_CNT_W'(4);
  localparam logic [FRAME_CNT_W-1:0] RST_EMERG_LOW      = FRAME_CNT_W'(2);
  localparam logic [FRAME_CNT_W-1:0] RST_EMERG_QUEUE    = FRAME_CNT_W'(2);
  localparam logic [AGE_W-1:0]       RST_MAX_AGE        = AGE_W'(1500);
  localparam logic [AGE_W-1:0]       RST_EMERG_MAX_AGE  = AGE_W'(500);

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_PREFILL_LOW    = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_PREFILL_HIGH   = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] CFG_NORMAL_TARGET  = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] CFG_PREFILL_TARGET = CFG_ADDR_W'(3);
  localparam logic [CFG_ADDR_W-1:0] CFG_EMERG_LOW      = CFG_ADDR_W'(4);
  localparam logic [CFG_ADDR_W-1:0] CFG_EMERG_QUEUE    = CFG_ADDR_W'(5);
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_AGE        = CFG_ADDR_W'(6);
  localparam logic [CFG_ADDR_W-1:0] CFG_EMERG_MAX_AGE  = CFG_ADDR_W'(7);

  typedef enum logic [IN_USER_W-1:0] {
    REQ_DECIDE        = 2'd0,
    REQ_WRITE_DONE    = 2'd1,
    REQ_SESSION_RESET = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_NORMAL    = 2'd1,
    MODE_PREFILL   = 2'd2,
    MODE_EMERGENCY = 2'd3
  } mode_t;

  typedef struct packed {
    logic [THR_W-1:0]       prefill_low_w;
    logic [THR_W-1:0]       prefill_high_w;
    logic [THR_W-1:0]       emerg_low_w;
    logic [FRAME_CNT_W-1:0] prefill_high;
    logic [FRAME_CNT_W-1:0] normal_target;
    logic [FRAME_CNT_W-1:0] prefill_target;
    logic [FRAME_CNT_W-1:0] emerg_queue;
    logic [AGE_W-1:0]       max_age;
    logic [AGE_W-1:0]       emerg_max_age;
  } trb_cfg_t;

  typedef struct packed {
    req_t                   req;
    logic [WORD_CNT_W-1:0]  fill_words;
    logic [WORD_CNT_W-1:0]  free_words;
    logic                   underflowed;
    logic [FRAME_CNT_W-1:0] queued;
    logic [AGE_W-1:0]       oldest_age;
    logic [WRITTEN_W-1:0]   written;
  } trb_in_t;

  // Handed from the classify stage to the decide stage
  typedef struct packed {
    req_t                   req;
    logic [FRAME_CNT_W-1:0] queued;
    logic [AGE_W-1:0]       oldest_age;
    logic [FRAME_CNT_W-1:0] fill_frames;   // only meaningful when fill_lt_high
    logic [FRAME_CNT_W-1:0] free_frames;   // saturated
    logic                   emergency;
    logic                   fill_lt_high;
    logic                   prefill;       // flag after this item
  } trb_stage_t;

  typedef struct packed {
    logic [BATCH_W-1:0]     frames;
    mode_t                  mode;
    logic [FRAME_CNT_W-1:0] target;
    logic [AGE_W-1:0]       wait_us;
    logic                   space_blocked;
    logic                   prefill;
  } trb_out_t;

  function automatic logic [FRAME_CNT_W-1:0] min_frames(
    input logic [FRAME_CNT_W-1:0] a,
    input logic [FRAME_CNT_W-1:0] b
  );
    return (a < b) ? a : b;
  endfunction

endpackage

@@ hw/rtl/trb_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trb_cfg_regs
// Policy registers; frame thresholds are also kept scaled to FIFO words.
// ----------------------------------------------------------------------------
module trb_cfg_regs #(
  parameter int WORDS_PER_FRAME = trb_pkg::WORDS_PER_FRAME_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [trb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [trb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output trb_pkg::trb_cfg_t               cfg
);
  import trb_pkg::*;

  localparam logic [THR_W-1:0] FRAME_WORDS = THR_W'(WORDS_PER_FRAME);

  trb_cfg_t               cfg_r;
  logic [FRAME_CNT_W-1:0] wr_frames;
  logic [THR_W-1:0]       wr_scaled;

  assign wr_frames = cfg_wdata[FRAME_CNT_W-1:0];
  assign wr_scaled = THR_W'(wr_frames) * FRAME_WORDS;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prefill_low_w  <= THR_W'(RST_PREFILL_LOW) * FRAME_WORDS;
      cfg_r.prefill_high_w <= THR_W'(RST_PREFILL_HIGH) * FRAME_WORDS;
      cfg_r.emerg_low_w    <= THR_W'(RST_EMERG_LOW) * FRAME_WORDS;
      cfg_r.prefill_high   <= RST_PREFILL_HIGH;
      cfg_r.normal_target  <= RST_NORMAL_TARGET;
      cfg_r.prefill_target <= RST_PREFILL_TARGET;
      cfg_r.emerg_queue    <= RST_EMERG_QUEUE;
      cfg_r.max_age        <= RST_MAX_AGE;
      cfg_r.emerg_max_age  <= RST_EMERG_MAX_AGE;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_PREFILL_LOW: begin
          cfg_r.prefill_low_w <= wr_scaled;
        end
        CFG_PREFILL_HIGH: begin
          cfg_r.prefill_high   <= wr_frames;
          cfg_r.prefill_high_w <= wr_scaled;
        end
        CFG_NORMAL_TARGET: begin
          cfg_r.normal_target <= wr_frames;
        end
        CFG_PREFILL_TARGET: begin
          cfg_r.prefill_target <= wr_frames;
        end
        CFG_EMERG_LOW: begin
          cfg_r.emerg_low_w <= wr_scaled;
        end
        CFG_EMERG_QUEUE: begin
          cfg_r.emerg_queue <= wr_frames;
        end
        CFG_MAX_AGE: begin
          cfg_r.max_age <= cfg_wdata[AGE_W-1:0];
        end
        CFG_EMERG_MAX_AGE: begin
          cfg_r.emerg_max_age <= cfg_wdata[AGE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/trb_classify.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trb_classify
// Input register, prefill flag with hysteresis and word-to-frame conversion.
// ----------------------------------------------------------------------------
module trb_classify #(
  parameter int WORDS_PER_FRAME = trb_pkg::WORDS_PER_FRAME_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  trb_pkg::trb_cfg_t    cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  trb_pkg::trb_in_t     in_item,
  output logic                 stg_valid,
  input  logic                 stg_ready,
  output trb_pkg::trb_stage_t  stg
);
  import trb_pkg::*;

  // Exact quotient of a 16-bit value by the frame size: (x * m) >> k with
  // k = 16 + ceil(log2 W) and m = ceil(2^k / W), which fits 17 bits.
  localparam int FRAME_SHIFT = WORD_CNT_W + $clog2(WORDS_PER_FRAME);
  localparam int RECIP_W     = WORD_CNT_W + 1;
  localparam int PROD_W      = WORD_CNT_W + RECIP_W;
  localparam logic [RECIP_W-1:0] FRAME_RECIP =
    RECIP_W'(((2 ** FRAME_SHIFT) + WORDS_PER_FRAME - 1) / WORDS_PER_FRAME);
  localparam logic [THR_W-1:0] FRAME_WORDS = THR_W'(WORDS_PER_FRAME);
  localparam logic [WORD_CNT_W-1:0] FRAME_SAT = WORD_CNT_W'({FRAME_CNT_W{1'b1}});

  logic                  s_valid_r;
  trb_in_t               s_item_r;
  logic                  flag_r;
  logic                  flag_nxt;

  logic [PROD_W-1:0]     fill_prod;
  logic [PROD_W-1:0]     free_prod;
  logic [WORD_CNT_W-1:0] fill_q;
  logic [WORD_CNT_W-1:0] free_q;
  logic [THR_W-1:0]      fill_ext;
  logic [THR_W-1:0]      done_words;
  logic                  lt_low;
  logic                  ge_high;
  logic                  flag_uf;

  assign in_ready  = !s_valid_r || stg_ready;
  assign stg_valid = s_valid_r;

  assign fill_prod = PROD_W'(s_item_r.fill_words) * PROD_W'(FRAME_RECIP);
  assign free_prod = PROD_W'(s_item_r.free_words) * PROD_W'(FRAME_RECIP);
  assign fill_q    = WORD_CNT_W'(fill_prod >> FRAME_SHIFT);
  assign free_q    = WORD_CNT_W'(free_prod >> FRAME_SHIFT);

  assign fill_ext   = THR_W'(s_item_r.fill_words);
  assign done_words = fill_ext + THR_W'(s_item_r.written) * FRAME_WORDS;
  assign lt_low     = fill_ext < cfg.prefill_low_w;
  assign ge_high    = fill_ext >= cfg.prefill_high_w;
  assign flag_uf    = flag_r || s_item_r.underflowed;

  always_comb begin
    case (s_item_r.req)
      REQ_DECIDE: begin
        // underflow sets the flag even when the queue is empty
        if (s_item_r.queued == '0) begin
          flag_nxt = flag_uf;
        end else if (lt_low) begin
          flag_nxt = 1'b1;
        end else if (ge_high) begin
          flag_nxt = 1'b0;
        end else begin
          flag_nxt = flag_uf;
        end
      end
      REQ_WRITE_DONE: begin
        flag_nxt = (done_words >= cfg.prefill_high_w) ? 1'b0 : flag_r;
      end
      REQ_SESSION_RESET: begin
        flag_nxt = 1'b1;
      end
      default: begin
        flag_nxt = flag_r;
      end
    endcase
  end

  always_comb begin
    stg.req          = s_item_r.req;
    stg.queued       = s_item_r.queued;
    stg.oldest_age   = s_item_r.oldest_age;
    stg.fill_frames  = fill_q[FRAME_CNT_W-1:0];
    stg.free_frames  = (free_q > FRAME_SAT) ? FRAME_SAT[FRAME_CNT_W-1:0]
                                            : free_q[FRAME_CNT_W-1:0];
    stg.emergency    = fill_ext < cfg.emerg_low_w;
    stg.fill_lt_high = fill_ext < cfg.prefill_high_w;
    stg.prefill      = flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      flag_r    <= 1'b1;
    end else begin
      if (in_ready) begin
        s_valid_r <= in_valid;
      end
      if (s_valid_r && stg_ready) begin
        flag_r <= flag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_item_r <= in_item;
    end
  end

endmodule

@@ hw/rtl/trb_decide.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trb_decide
// Mode, target, batch size and wait selection, with the result register.
// ----------------------------------------------------------------------------
module trb_decide #(
  parameter int MAX_BATCH_FRAMES = trb_pkg::MAX_BATCH_FRAMES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  trb_pkg::trb_cfg_t    cfg,
  input  logic                 stg_valid,
  output logic                 stg_ready,
  input  trb_pkg::trb_stage_t  stg,
  output logic                 res_valid,
  input  logic                 res_ready,
  output trb_pkg::trb_out_t    res
);
  import trb_pkg::*;

  localparam logic [FRAME_CNT_W-1:0] MAX_BATCH = FRAME_CNT_W'(MAX_BATCH_FRAMES);

  logic                   m_valid_r;
  trb_stage_t             m_r;
  logic                   o_valid_r;
  trb_out_t               o_r;
  trb_out_t               res_nxt;
  logic                   o_adv;

  logic [FRAME_CNT_W-1:0] target;
  logic [FRAME_CNT_W-1:0] out_target;
  logic [AGE_W-1:0]       limit;
  logic [AGE_W-1:0]       age_gap;
  logic [AGE_W-1:0]       wait_sel;
  logic [FRAME_CNT_W-1:0] refill_gap;
  logic [FRAME_CNT_W:0]   big_level;
  logic                   want;
  logic [FRAME_CNT_W-1:0] frames_raw;
  logic [FRAME_CNT_W-1:0] frames_clip;
  logic [FRAME_CNT_W-1:0] frames_fit;
  mode_t                  mode;

  assign o_adv     = !o_valid_r || res_ready;
  assign stg_ready = !m_valid_r || o_adv;
  assign res_valid = o_valid_r;
  assign res       = o_r;

  assign target     = m_r.prefill ? cfg.prefill_target : cfg.normal_target;
  assign out_target = m_r.emergency ? min_frames(target, cfg.emerg_queue) : target;
  assign limit      = m_r.emergency ? cfg.emerg_max_age : cfg.max_age;
  assign refill_gap = cfg.prefill_high - m_r.fill_frames;
  assign big_level  = (FRAME_CNT_W + 1)'(target) * (FRAME_CNT_W + 1)'(BIG_QUEUE_FACTOR);

  assign age_gap  = limit - m_r.oldest_age;
  assign wait_sel = (m_r.oldest_age >= limit || age_gap > IDLE_POLL_US) ? IDLE_POLL_US
                                                                          : age_gap;

  always_comb begin
    if (m_r.emergency) begin
      mode       = MODE_EMERGENCY;
      want       = (m_r.queued >= cfg.emerg_queue) ||
                   (m_r.oldest_age >= cfg.emerg_max_age);
      frames_raw = m_r.fill_lt_high ? refill_gap : cfg.emerg_queue;
    end else if (m_r.prefill) begin
      mode       = MODE_PREFILL;
      want       = (m_r.queued >= target) || (m_r.oldest_age >= cfg.max_age);
      frames_raw = m_r.fill_lt_high ? refill_gap : target;
    end else begin
      mode       = MODE_NORMAL;
      want       = (m_r.queued >= target) || (m_r.oldest_age >= cfg.max_age);
      // a deep queue is taken whole, up to the batch limit and the free space
      frames_raw = ({1'b0, m_r.queued} > big_level) ? m_r.queued : target;
    end
  end

  assign frames_clip = want ? min_frames(min_frames(frames_raw, m_r.queued), MAX_BATCH)
                            : '0;
  assign frames_fit  = min_frames(frames_clip, m_r.free_frames);

  always_comb begin
    res_nxt         = '0;
    res_nxt.prefill = m_r.prefill;
    if (m_r.req == REQ_DECIDE) begin
      if (m_r.queued == '0) begin
        res_nxt.wait_us = IDLE_POLL_US;
      end else begin
        res_nxt.mode   = mode;
        res_nxt.target = out_target;
        if (frames_clip == '0) begin
          res_nxt.wait_us = wait_sel;
        end else if (m_r.free_frames == '0) begin
          res_nxt.space_blocked = 1'b1;
          res_nxt.wait_us       = SPACE_POLL_US;
        end else begin
          res_nxt.frames = frames_fit[BATCH_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (stg_ready) begin
        m_valid_r <= stg_valid;
      end
      if (o_adv) begin
        o_valid_r <= m_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg_valid && stg_ready) begin
      m_r <= stg;
    end
    if (m_valid_r && o_adv) begin
      o_r <= res_nxt;
    end
  end

endmodule

@@ hw/rtl/tx_fifo_refill_batch_policy.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tx_fifo_refill_batch_policy
// Decides how many queued frames to burst into the transmit FIFO.
// ----------------------------------------------------------------------------
// Requests enter on the in_ stream, in_tuser carrying the request kind
// (decide, write done, session reset) and in_tdata the FIFO and queue status.
// Every request gives exactly one result transfer on the out_ stream: batch
// size, mode, target, wait time, space-blocked flag and the prefill flag.
// Policy registers are written through cfg_wr_en / cfg_addr / cfg_wdata and
// take effect at once; write them only while no request is in flight.
//
// An input transfer loads the input register, frame conversion and prefill
// hysteresis feed the middle register, then selection feeds the result
// register, which drives out_tvalid. One request is taken every cycle
// unless the output stalls; the prefill flag loop closes within the first
// stage, so back-to-back requests see each other's flag updates in order.
// Each stage holds its item while the next one is full, so a stalled receiver
// fills the pipeline and in_tready drops once all three stages hold results.
// Reset empties the pipeline, restores the register defaults and sets the
// prefill flag.
// ----------------------------------------------------------------------------
module tx_fifo_refill_batch_policy #(
  parameter int WORDS_PER_FRAME  = trb_pkg::WORDS_PER_FRAME_DEF,
  parameter int MAX_BATCH_FRAMES = trb_pkg::MAX_BATCH_FRAMES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // req_type[1:0]
  input  logic [trb_pkg::IN_USER_W-1:0]   in_tuser,
  // fifo_fill_words[15:0], fifo_free_words[31:16], fifo_underflowed[32],
  // queued_frames[38:33], oldest_age_us[54:39], frames_written[58:55]
  input  logic [trb_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // frames_to_write[3:0], write_mode[5:4], target_frames[11:6],
  // wait_us[27:12], space_blocked[28], prefill_active[29]
  output logic [trb_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [trb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [trb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import trb_pkg::*;

  trb_cfg_t   cfg;
  trb_in_t    in_item;
  trb_stage_t stg;
  logic       stg_valid;
  logic       stg_ready;
  trb_out_t   res;

  assign in_item.req         = req_t'(in_tuser);
  assign in_item.fill_words  = in_tdata[15:0];
  assign in_item.free_words  = in_tdata[31:16];
  assign in_item.underflowed = in_tdata[32];
  assign in_item.queued      = in_tdata[38:33];
  assign in_item.oldest_age  = in_tdata[54:39];
  assign in_item.written     = in_tdata[58:55];

  assign out_tdata = {2'b00, res.prefill, res.space_blocked, res.wait_us,
                      res.target, res.mode, res.frames};

  trb_cfg_regs #(
    .WORDS_PER_FRAME (WORDS_PER_FRAME)
  ) u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  trb_classify #(
    .WORDS_PER_FRAME (WORDS_PER_FRAME)
  ) u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .stg_valid (stg_valid),
    .stg_ready (stg_ready),
    .stg       (stg)
  );

  trb_decide #(
    .MAX_BATCH_FRAMES (MAX_BATCH_FRAMES)
  ) u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .stg_valid (stg_valid),
    .stg_ready (stg_ready),
    .stg       (stg),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

endmodule

@@ hw/rtl/trb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trb_checker
// Port-level checks on the result stream of the refill batch policy.
// ----------------------------------------------------------------------------
module trb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [trb_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import trb_pkg::*;

  logic [BATCH_W-1:0] frames;
  logic [1:0]         mode;
  logic [AGE_W-1:0]   wait_us;
  logic               blocked;

  assign frames  = out_tdata[3:0];
  assign mode    = out_tdata[5:4];
  assign wait_us = out_tdata[27:12];
  assign blocked = out_tdata[28];

  // pipeline is empty straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a burst carries no wait and comes from an active mode
  a_burst_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && frames != '0 |-> wait_us == '0 && !blocked && mode != MODE_IDLE)
    else $error("burst result with wait, block or idle mode");

  a_blocked_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && blocked |-> frames == '0 && wait_us == SPACE_POLL_US)
    else $error("space-blocked result with frames or wrong poll time");

endmodule

bind tx_fifo_refill_batch_policy trb_checker u_trb_checker (.*);
